### rtl/core/rdq_pkg.sv
// ----------------------------------------------------------------------------
// Restricted double-ended queue: shared definitions
// Request and status codes, mode codes and the transaction structs used by
// the queue core and its engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

  // Width of one stored item.
  localparam int unsigned ITEM_W  = 32;
  // Width of the reported item count.
  localparam int unsigned COUNT_W = 5;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INS_REAR  = 2'd0,
    REQ_INS_FRONT = 2'd1,
    REQ_DEL_REAR  = 2'd2,
    REQ_DEL_FRONT = 2'd3
  } req_e_t;

  // Status codes.
  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_ALLOWED = 2'd3
  } status_e_t;

  // Restriction mode codes.
  localparam logic MODE_IN_RESTRICT  = 1'b0;
  localparam logic MODE_OUT_RESTRICT = 1'b1;

  // One request transaction.
  typedef struct packed {
    req_e_t                    req_type;
    logic signed [ITEM_W-1:0]  item_value;
  } rdq_in_t;

  // One result transaction.
  typedef struct packed {
    status_e_t                 status;
    logic signed [ITEM_W-1:0]  removed_value;
    logic [COUNT_W-1:0]        item_count;
    logic signed [ITEM_W-1:0]  front_value;
    logic signed [ITEM_W-1:0]  rear_value;
  } rdq_out_t;

endpackage : rdq_pkg

`default_nettype wire

### rtl/core/rdq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem_r[rd_addr_a];
    rd_data_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule : rdq_ram

`default_nettype wire

### rtl/core/rdq_engine.sv
// ----------------------------------------------------------------------------
// Restricted double-ended queue engine
// Holds head index, count and cached front and rear items, decides each
// request combinationally and registers the result. The item store sits in a
// RAM; the entries next to the front and the rear are read ahead from the
// next state so that a delete finds its new end item waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_engine
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     accept,
  input  wire rdq_in_t                  in_req,
  input  wire logic                     mode,
  input  wire logic [ITEM_W-1:0]        inner_front,
  input  wire logic [ITEM_W-1:0]        inner_rear,
  output logic                          mem_we,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr,
  output logic      [ITEM_W-1:0]        mem_wdata,
  output logic      [$clog2(DEPTH)-1:0] rd_front_addr,
  output logic      [$clog2(DEPTH)-1:0] rd_rear_addr,
  output logic                          out_valid,
  output rdq_out_t                      out_res
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  // Ring index helpers.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) res = '0;
    else                          res = idx + 1'b1;
    return res;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == '0) res = IDX_W'(DEPTH - 1);
    else           res = idx - 1'b1;
    return res;
  endfunction

  // Position one past the rear: (head + count) mod DEPTH, sum below 2*DEPTH.
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] cnt);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;
    sum = SUM_W'(head) + SUM_W'(cnt);
    if (sum >= SUM_W'(DEPTH)) wrapped = sum - SUM_W'(DEPTH);
    else                      wrapped = sum;
    return wrapped[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ITEM_W-1:0] front_r, front_nxt;
  logic [ITEM_W-1:0] rear_r, rear_nxt;
  logic              out_valid_r;
  rdq_out_t          res_r, res_nxt;

  logic              full;
  logic              empty;
  logic              two_left;
  logic              forbidden;
  logic [IDX_W-1:0]  ins_rear_pos;
  logic [IDX_W-1:0]  ins_front_pos;
  logic [IDX_W-1:0]  tail_nxt;
  status_e_t         status;
  logic [ITEM_W-1:0] removed;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign full          = (count_r == CNT_W'(DEPTH));
  assign empty         = (count_r == '0);
  assign two_left      = (count_r == CNT_W'(2));
  assign ins_rear_pos  = idx_add(head_r, count_r);
  assign ins_front_pos = idx_dec(head_r);

  // Mode check: the forbidden operation is rejected before anything else.
  assign forbidden = ((mode == MODE_IN_RESTRICT)  && (in_req.req_type == REQ_INS_FRONT)) ||
                     ((mode == MODE_OUT_RESTRICT) && (in_req.req_type == REQ_DEL_REAR));

  // Request decision and next queue state.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    status    = ST_DONE;
    removed   = '0;
    mem_we    = 1'b0;
    mem_waddr = ins_rear_pos;
    mem_wdata = in_req.item_value;
    if (accept) begin
      if (forbidden) begin
        status = ST_NOT_ALLOWED;
      end else begin
        unique case (in_req.req_type)
          REQ_INS_REAR: begin
            if (full) begin
              status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ins_rear_pos;
              count_nxt = count_r + 1'b1;
              rear_nxt  = in_req.item_value;
              if (empty) front_nxt = in_req.item_value;
            end
          end
          REQ_INS_FRONT: begin
            if (full) begin
              status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ins_front_pos;
              head_nxt  = ins_front_pos;
              count_nxt = count_r + 1'b1;
              front_nxt = in_req.item_value;
              if (empty) rear_nxt = in_req.item_value;
            end
          end
          REQ_DEL_REAR: begin
            if (empty) begin
              status = ST_EMPTY;
            end else begin
              removed   = rear_r;
              count_nxt = count_r - 1'b1;
              // With one item left the rear is the cached front.
              rear_nxt  = two_left ? front_r : inner_rear;
            end
          end
          REQ_DEL_FRONT: begin
            if (empty) begin
              status = ST_EMPTY;
            end else begin
              removed   = front_r;
              head_nxt  = idx_inc(head_r);
              count_nxt = count_r - 1'b1;
              // With one item left the front is the cached rear.
              front_nxt = two_left ? rear_r : inner_front;
            end
          end
          default: status = ST_DONE;
        endcase
      end
    end
  end

  // Read ahead the entries next to the front and the rear of the next state.
  assign tail_nxt      = idx_dec(idx_add(head_nxt, count_nxt));
  assign rd_front_addr = idx_inc(head_nxt);
  assign rd_rear_addr  = idx_dec(tail_nxt);

  // Result transaction.
  always_comb begin
    count_wide            = (CNT_W + COUNT_W)'(count_nxt);
    res_nxt.status        = status;
    res_nxt.removed_value = removed;
    res_nxt.item_count    = count_wide[COUNT_W-1:0];
    res_nxt.front_value   = (count_nxt == '0) ? '0 : front_nxt;
    res_nxt.rear_value    = (count_nxt == '0) ? '0 : rear_nxt;
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  // Cached end items and result payload.
  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    rear_r  <= rear_nxt;
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule : rdq_engine

`default_nettype wire

### rtl/core/restricted_double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Restricted double-ended queue core
// A bounded ring of signed 32-bit items with front and rear insert and
// delete, one operation forbidden by the restriction mode.
//
//   Channel   Ports                     Handshake
//   request   start, busy, in_req       taken when start is high, busy low
//   result    out_valid, out_res        one-cycle strobe, cannot be held off
//   config    cfg_wr_en, cfg_wr_data    written when cfg_wr_en is high
//
// A request is taken every cycle; busy stays low.
// Its result appears on the cycle after it is taken, set by the single
// result register that follows the request decision.
// Reset clears head, count, mode and the result strobe; the item RAM is
// not cleared and needs no clearing pass.
// The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
`default_nettype none

module restricted_double_ended_queue_core
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire rdq_in_t in_req,
  output logic         out_valid,
  output rdq_out_t     out_res,
  input  wire logic    cfg_wr_en,
  input  wire logic    cfg_wr_data
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic              mode_r;
  logic              accept;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ITEM_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  rd_front_addr;
  logic [IDX_W-1:0]  rd_rear_addr;
  logic [ITEM_W-1:0] inner_front;
  logic [ITEM_W-1:0] inner_rear;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Restriction mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IN_RESTRICT;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Request decision and queue state.
  rdq_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_req        (in_req),
    .mode          (mode_r),
    .inner_front   (inner_front),
    .inner_rear    (inner_rear),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .rd_front_addr (rd_front_addr),
    .rd_rear_addr  (rd_rear_addr),
    .out_valid     (out_valid),
    .out_res       (out_res)
  );

  // Item store.
  rdq_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_addr_a (rd_front_addr),
    .rd_addr_b (rd_rear_addr),
    .rd_data_a (inner_front),
    .rd_data_b (inner_rear)
  );

  // Every taken transaction yields a result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && accept |=> out_valid)
    else $error("accepted transaction produced no result");

  // A result only follows a taken transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !accept |=> !out_valid)
    else $error("result without an accepted transaction");

  // The RAM is written only for a taken transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> accept)
    else $error("item store written without a transaction");

  // A rejected or failed request removes nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status != ST_DONE) |-> (out_res.removed_value == '0))
    else $error("nonzero removed value on a failed request");

  // A mode rejection matches the mode and request of the previous cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.status == ST_NOT_ALLOWED) |->
      (($past(mode_r) == MODE_IN_RESTRICT) && ($past(in_req.req_type) == REQ_INS_FRONT)) ||
      (($past(mode_r) == MODE_OUT_RESTRICT) && ($past(in_req.req_type) == REQ_DEL_REAR)))
    else $error("mode rejection for an allowed request");

endmodule : restricted_double_ended_queue_core

`default_nettype wire
